// ===== hdl/mcsm_pkg.sv =====
// shared types and constants of the motor command state machine
package mcsm_pkg;

  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned DutyW    = 10;
  localparam int unsigned SpeedW   = 7;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned OutDataW = 40;

  localparam logic [DutyW-1:0] DutyMax = 10'd1000;
  localparam logic [DutyW-1:0] RpmMax  = 10'd1000;

  localparam logic [1:0] REG_START_DUTY  = 2'd0;
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd1;
  localparam logic [1:0] REG_RPM_LIMIT   = 2'd2;

  localparam logic [DutyW-1:0]  START_DUTY_RST  = 10'd200;
  localparam logic [SpeedW-1:0] SPEED_LIMIT_RST = 7'd100;
  localparam logic [DutyW-1:0]  RPM_LIMIT_RST   = 10'd1000;

  typedef enum logic [1:0] {
    ST_STOP = 2'd0,
    ST_PWM  = 2'd1,
    ST_GPIO = 2'd2,
    ST_ERR  = 2'd3
  } drive_state_e;

  typedef enum logic [1:0] {
    DIR_FWD = 2'd1,
    DIR_REV = 2'd2
  } direction_e;

  typedef enum logic [3:0] {
    REQ_ON       = 4'd0,
    REQ_OFF      = 4'd1,
    REQ_SPEED    = 4'd2,
    REQ_MODE_GPIO = 4'd3,
    REQ_MODE_PWM = 4'd4,
    REQ_FWD      = 4'd5,
    REQ_REV      = 4'd6,
    REQ_STATUS   = 4'd7,
    REQ_SET_RPM  = 4'd8,
    REQ_AUTO     = 4'd9,
    REQ_STALL    = 4'd10,
    REQ_UNKNOWN  = 4'd11
  } req_e;

  typedef enum logic [4:0] {
    RPL_STARTED      = 5'd0,
    RPL_STOPPED      = 5'd1,
    RPL_SPEED_SET    = 5'd2,
    RPL_FWD          = 5'd3,
    RPL_REV          = 5'd4,
    RPL_GPIO         = 5'd5,
    RPL_PWM          = 5'd6,
    RPL_STAT_PWM     = 5'd7,
    RPL_STAT_GPIO    = 5'd8,
    RPL_RECOVERED    = 5'd9,
    RPL_MUST_RECOVER = 5'd10,
    RPL_STALLED      = 5'd11,
    RPL_INVALID      = 5'd12,
    RPL_SPEED_RANGE  = 5'd13,
    RPL_RPM_RANGE    = 5'd14,
    RPL_PID_SET      = 5'd15,
    RPL_AUTO         = 5'd16,
    RPL_UNKNOWN      = 5'd17,
    RPL_SILENT       = 5'd18
  } reply_e;

  typedef struct packed {
    logic [DutyW-1:0]  start_duty;
    logic [SpeedW-1:0] speed_limit;
    logic [DutyW-1:0]  rpm_limit;
  } cfg_t;

  typedef struct packed {
    logic             loop_reset;
    logic [DutyW-1:0] target_speed;
    logic             closed_loop;
    logic             stop_pulse;
    logic [DutyW-1:0] duty;
    direction_e       direction;
    logic             drive_mode;
    drive_state_e     drive_state;
    reply_e           reply_code;
  } result_t;

endpackage

// ===== hdl/mcsm_regs.sv =====
// configuration register file behind the apb port
module mcsm_regs
  import mcsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t        cfg_q, cfg_d;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[CfgAddrW-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_START_DUTY:  cfg_d.start_duty  = pwdata[DutyW-1:0];
        REG_SPEED_LIMIT: cfg_d.speed_limit = pwdata[SpeedW-1:0];
        REG_RPM_LIMIT:   cfg_d.rpm_limit   = pwdata[DutyW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_duty  <= START_DUTY_RST;
      cfg_q.speed_limit <= SPEED_LIMIT_RST;
      cfg_q.rpm_limit   <= RPM_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_START_DUTY:  prdata = {22'd0, cfg_q.start_duty};
      REG_SPEED_LIMIT: prdata = {25'd0, cfg_q.speed_limit};
      REG_RPM_LIMIT:   prdata = {22'd0, cfg_q.rpm_limit};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/mcsm_core.sv =====
// input register, command decode and drive state update, result register
module mcsm_core
  import mcsm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0]        in_req_i,
  input  logic [ValueW-1:0] in_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output result_t           out_res_o
);

  logic              in_valid_q;
  logic [3:0]        in_req_q;
  logic [ValueW-1:0] in_value_q;
  logic              advance;

  logic              out_valid_q;
  result_t           res_q, res_d;

  drive_state_e      state_q, state_d;
  logic              mode_q, mode_d;
  direction_e        dir_q, dir_d;
  logic [DutyW-1:0]  duty_q, duty_d;
  logic              cl_q, cl_d;
  logic [DutyW-1:0]  target_q, target_d;

  logic              speed_ok, rpm_ok, run, stopped, lreset;
  logic [DutyW-1:0]  rpm_lim, start_sat, speed_duty;
  logic [DutyW:0]    speed_prod;
  reply_e            reply;

  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_req_q   <= in_req_i;
      in_value_q <= in_value_i;
    end
  end

  assign rpm_lim    = (cfg_i.rpm_limit > RpmMax) ? RpmMax : cfg_i.rpm_limit;
  assign start_sat  = (cfg_i.start_duty > DutyMax) ? DutyMax : cfg_i.start_duty;
  assign speed_ok   = ~in_value_q[ValueW-1] &&
                      (in_value_q[ValueW-2:0] <= {{(ValueW-1-SpeedW){1'b0}}, cfg_i.speed_limit});
  assign rpm_ok     = ~in_value_q[ValueW-1] &&
                      (in_value_q[ValueW-2:0] <= {{(ValueW-1-DutyW){1'b0}}, rpm_lim});
  assign speed_prod = {{(DutyW+1-SpeedW){1'b0}}, in_value_q[SpeedW-1:0]} * (DutyW+1)'(10);
  assign speed_duty = (speed_prod > {1'b0, DutyMax}) ? DutyMax : speed_prod[DutyW-1:0];

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    dir_d    = dir_q;
    duty_d   = duty_q;
    cl_d     = cl_q;
    target_d = target_q;
    stopped  = 1'b0;
    lreset   = 1'b0;
    run      = 1'b0;
    reply    = RPL_UNKNOWN;

    unique case (in_req_q)
      REQ_SPEED: begin
        if (speed_ok) run = 1'b1;
        else reply = RPL_SPEED_RANGE;
      end
      REQ_SET_RPM: begin
        if (rpm_ok) begin
          target_d = in_value_q[DutyW-1:0];
          cl_d     = 1'b1;
          lreset   = 1'b1;
          reply    = RPL_PID_SET;
        end else begin
          reply = RPL_RPM_RANGE;
        end
      end
      REQ_AUTO: begin
        cl_d  = 1'b0;
        reply = RPL_AUTO;
      end
      REQ_ON, REQ_OFF, REQ_MODE_GPIO, REQ_MODE_PWM, REQ_FWD, REQ_REV,
      REQ_STATUS, REQ_STALL: run = 1'b1;
      default: reply = RPL_UNKNOWN;
    endcase

    if (run) begin
      reply = RPL_INVALID;
      priority if (state_q == ST_ERR) begin
        if (in_req_q == REQ_ON) begin
          state_d = ST_STOP;
          duty_d  = '0;
          stopped = 1'b1;
          reply   = RPL_RECOVERED;
        end else begin
          reply = RPL_MUST_RECOVER;
        end
      end else if (in_req_q == REQ_STALL) begin
        state_d = ST_ERR;
        duty_d  = '0;
        stopped = 1'b1;
        reply   = RPL_STALLED;
      end else if (state_q == ST_STOP) begin
        if (in_req_q == REQ_ON) begin
          state_d = ST_PWM;
          mode_d  = 1'b1;
          dir_d   = DIR_FWD;
          duty_d  = start_sat;
          reply   = RPL_STARTED;
        end else if (in_req_q == REQ_MODE_GPIO) begin
          state_d = ST_GPIO;
          mode_d  = 1'b0;
          reply   = RPL_GPIO;
        end else if (in_req_q == REQ_MODE_PWM) begin
          state_d = ST_PWM;
          mode_d  = 1'b1;
          reply   = RPL_PWM;
        end
      end else if (in_req_q == REQ_OFF) begin
        state_d = ST_STOP;
        duty_d  = '0;
        stopped = 1'b1;
        reply   = RPL_STOPPED;
      end else if (in_req_q == REQ_FWD) begin
        dir_d = DIR_FWD;
        reply = RPL_FWD;
      end else if (in_req_q == REQ_REV) begin
        dir_d = DIR_REV;
        reply = RPL_REV;
      end else if (state_q == ST_PWM) begin
        if (in_req_q == REQ_SPEED) begin
          duty_d = speed_duty;
          reply  = RPL_SPEED_SET;
        end else if (in_req_q == REQ_MODE_GPIO) begin
          state_d = ST_GPIO;
          mode_d  = 1'b0;
          reply   = RPL_GPIO;
        end else if (in_req_q == REQ_STATUS) begin
          reply = RPL_STAT_PWM;
        end
      end else begin
        if (in_req_q == REQ_MODE_PWM) begin
          state_d = ST_PWM;
          mode_d  = 1'b1;
          reply   = RPL_PWM;
        end else if (in_req_q == REQ_STATUS) begin
          reply = RPL_STAT_GPIO;
        end
      end
    end

    res_d.reply_code   = reply;
    res_d.drive_state  = state_d;
    res_d.drive_mode   = mode_d;
    res_d.direction    = dir_d;
    res_d.duty         = duty_d;
    res_d.stop_pulse   = stopped;
    res_d.closed_loop  = cl_d;
    res_d.target_speed = target_d;
    res_d.loop_reset   = lreset;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_STOP;
      mode_q      <= 1'b0;
      dir_q       <= DIR_FWD;
      duty_q      <= '0;
      cl_q        <= 1'b0;
      target_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q  <= state_d;
        mode_q   <= mode_d;
        dir_q    <= dir_d;
        duty_q   <= duty_d;
        cl_q     <= cl_d;
        target_q <= target_d;
      end
      if (advance) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

`ifndef SYNTHESIS
  a_err_no_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ERR) |-> (duty_q == '0))
    else $error("duty nonzero in error state");
  a_duty_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q <= DutyMax)
    else $error("duty above limit");
  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.stop_pulse) |-> (res_q.duty == '0))
    else $error("stop word with nonzero duty");
  a_lreset_cl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.loop_reset) |-> res_q.closed_loop)
    else $error("loop reset without closed loop");
  a_state_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (res_q.drive_state == state_q))
    else $error("result state differs from drive state");
`endif

endmodule

// ===== hdl/motor_command_state_machine.sv =====
// top level of the motor command state machine
//
// channel   dir  tdata / data                           tuser
// s_axis    in   value[15:0]                            req_type[3:0]
// m_axis    out  reply,state,mode,dir,duty,stop,cl,...  -
// apb       in   start_duty, speed_limit, rpm_limit     -
//
// one command word per cycle sustained while m_axis_tready is high; the input register
// and the result register sit around the decode logic.
// reset: drive stopped, gpio mode, forward, zero duty, open loop, target 0;
// registers return to start_duty 200, speed_limit 100, rpm_limit 1000.
// with m_axis_tready low the result holds and one more word is taken in.
module motor_command_state_machine
  import mcsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ValueW-1:0]   s_axis_tdata,  // value[15:0]
  input  logic [3:0]          s_axis_tuser,  // req_type[3:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // reply_code[4:0], drive_state_out[6:5], drive_mode_out[7], direction_out[9:8],
  // duty_out[19:10], stop_pulse[20], closed_loop_out[21], target_speed_out[31:22],
  // loop_reset_pulse[32], zero[39:33]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t    cfg;
  result_t res;

  mcsm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mcsm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (s_axis_tuser),
    .in_value_i  (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {7'd0, res};

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the motor command state machine
module tb_top
  import mcsm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CycleLimit        = 400000;
  localparam int          LongHold          = 200;
  localparam int          SettleCycles      = 4;
  localparam int          DutyPerSpeedStep  = 10;
  localparam logic [3:0]  ReqCodeMax        = 4'hF;
  localparam logic        MODE_GPIO         = 1'b0;
  localparam logic        MODE_PWM          = 1'b1;

  class drive_reply_tracker;
    logic [DutyW-1:0]  start_duty;
    logic [SpeedW-1:0] speed_limit;
    logic [DutyW-1:0]  rpm_limit;
    drive_state_e      drv_state;
    logic              mode;
    direction_e        dir;
    logic [DutyW-1:0]  duty;
    logic              closed_loop;
    logic [DutyW-1:0]  target;
    result_t           replies_due[$];
    int                errors;

    function new();
      start_duty  = START_DUTY_RST;
      speed_limit = SPEED_LIMIT_RST;
      rpm_limit   = RPM_LIMIT_RST;
      drv_state   = ST_STOP;
      mode        = MODE_GPIO;
      dir         = DIR_FWD;
      duty        = '0;
      closed_loop = 1'b0;
      target      = '0;
      errors      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      unique case (idx)
        REG_START_DUTY:  start_duty  = data[DutyW-1:0];
        REG_SPEED_LIMIT: speed_limit = data[SpeedW-1:0];
        REG_RPM_LIMIT:   rpm_limit   = data[DutyW-1:0];
        default: ;
      endcase
    endfunction

    // state machine part: everything except set_rpm, auto and unknown codes
    function reply_e drive_event(logic [3:0] req, int v, output logic stopped);
      int scaled;
      stopped = 1'b0;
      if (drv_state == ST_ERR) begin
        if (req == REQ_ON) begin
          drv_state = ST_STOP;
          duty      = '0;
          stopped   = 1'b1;
          return RPL_RECOVERED;
        end
        return RPL_MUST_RECOVER;
      end
      if (req == REQ_STALL) begin
        drv_state = ST_ERR;
        duty      = '0;
        stopped   = 1'b1;
        return RPL_STALLED;
      end
      if (drv_state == ST_STOP) begin
        unique case (req)
          REQ_ON: begin
            drv_state = ST_PWM;
            mode      = MODE_PWM;
            dir       = DIR_FWD;
            duty      = (start_duty > DutyMax) ? DutyMax : start_duty;
            return RPL_STARTED;
          end
          REQ_MODE_GPIO: begin
            drv_state = ST_GPIO;
            mode      = MODE_GPIO;
            return RPL_GPIO;
          end
          REQ_MODE_PWM: begin
            drv_state = ST_PWM;
            mode      = MODE_PWM;
            return RPL_PWM;
          end
          default: return RPL_INVALID;
        endcase
      end
      if (req == REQ_OFF) begin
        drv_state = ST_STOP;
        duty      = '0;
        stopped   = 1'b1;
        return RPL_STOPPED;
      end
      if (req == REQ_FWD) begin
        dir = DIR_FWD;
        return RPL_FWD;
      end
      if (req == REQ_REV) begin
        dir = DIR_REV;
        return RPL_REV;
      end
      if (drv_state == ST_PWM) begin
        if (req == REQ_SPEED) begin
          scaled = v * DutyPerSpeedStep;
          duty   = (scaled > DutyMax) ? DutyMax : scaled[DutyW-1:0];
          return RPL_SPEED_SET;
        end
        if (req == REQ_MODE_GPIO) begin
          drv_state = ST_GPIO;
          mode      = MODE_GPIO;
          return RPL_GPIO;
        end
        if (req == REQ_STATUS) return RPL_STAT_PWM;
        return RPL_INVALID;
      end
      if (req == REQ_MODE_PWM) begin
        drv_state = ST_PWM;
        mode      = MODE_PWM;
        return RPL_PWM;
      end
      if (req == REQ_STATUS) return RPL_STAT_GPIO;
      return RPL_INVALID;
    endfunction

    function result_t predict_reply(logic [3:0] req, logic signed [ValueW-1:0] val);
      result_t r;
      reply_e  code;
      int      v;
      int      rpm_cap;
      logic    stopped;
      logic    loop_reset;
      v          = val;
      stopped    = 1'b0;
      loop_reset = 1'b0;
      rpm_cap    = (rpm_limit > RpmMax) ? RpmMax : rpm_limit;
      if (req == REQ_SPEED) begin
        if (v < 0 || v > int'(speed_limit)) code = RPL_SPEED_RANGE;
        else code = drive_event(req, v, stopped);
      end else if (req == REQ_SET_RPM) begin
        if (v < 0 || v > rpm_cap) begin
          code = RPL_RPM_RANGE;
        end else begin
          target      = v[DutyW-1:0];
          closed_loop = 1'b1;
          loop_reset  = 1'b1;
          code        = RPL_PID_SET;
        end
      end else if (req == REQ_AUTO) begin
        closed_loop = 1'b0;
        code        = RPL_AUTO;
      end else if (req <= REQ_STATUS || req == REQ_STALL) begin
        code = drive_event(req, v, stopped);
      end else begin
        code = RPL_UNKNOWN;
      end
      r.reply_code   = code;
      r.drive_state  = drv_state;
      r.drive_mode   = mode;
      r.direction    = dir;
      r.duty         = duty;
      r.stop_pulse   = stopped;
      r.closed_loop  = closed_loop;
      r.target_speed = target;
      r.loop_reset   = loop_reset;
      return r;
    endfunction

    function void note_command(logic [3:0] req, logic signed [ValueW-1:0] val);
      replies_due.push_back(predict_reply(req, val));
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (replies_due.size() == 0) begin
        $error("reply word with no command outstanding: %h", got);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      compare_field("reply_code", want.reply_code, got.reply_code);
      compare_field("drive_state_out", want.drive_state, got.drive_state);
      compare_field("drive_mode_out", want.drive_mode, got.drive_mode);
      compare_field("direction_out", want.direction, got.direction);
      compare_field("duty_out", want.duty, got.duty);
      compare_field("stop_pulse", want.stop_pulse, got.stop_pulse);
      compare_field("closed_loop_out", want.closed_loop, got.closed_loop);
      compare_field("target_speed_out", want.target_speed, got.target_speed);
      compare_field("loop_reset_pulse", want.loop_reset, got.loop_reset);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ValueW-1:0]   s_axis_tdata;  // value[15:0]
  logic [3:0]          s_axis_tuser;  // req_type[3:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // reply_code, drive_state_out, drive_mode_out, direction_out, duty_out,
  // stop_pulse, closed_loop_out, target_speed_out, loop_reset_pulse, zero pad
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  drive_reply_tracker board = new();
  bit                 idle_on  = 1'b1;
  bit                 hold_req = 1'b0;

  motor_command_state_machine DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_reply(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // reply side: random stalls plus one long hold on request
  initial begin : reply_sink
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        hold_req      = 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end else if (idle_on && rst_ni && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
    end
  end

  task automatic send_cmd(logic [3:0] req, logic [ValueW-1:0] val);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = val;
    s_axis_tuser  = req;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_command(req, val);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_reg(idx, data);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_limits(int unsigned sd, int unsigned sl, int unsigned rl);
    apb_write(REG_START_DUTY, sd);
    apb_write(REG_SPEED_LIMIT, sl);
    apb_write(REG_RPM_LIMIT, rl);
  endtask

  // mostly sensible command sequences, with out-of-range values and junk codes
  task automatic run_random(int n);
    logic [3:0]        req;
    logic [ValueW-1:0] val;
    int                pick;
    int                rpm_cap;
    for (int i = 0; i < n; i++) begin
      pick    = $urandom_range(0, 99);
      val     = ValueW'($urandom);
      rpm_cap = (board.rpm_limit > RpmMax) ? RpmMax : board.rpm_limit;
      if (pick < 14) begin
        req = REQ_ON;
      end else if (pick < 21) begin
        req = REQ_OFF;
      end else if (pick < 41) begin
        req = REQ_SPEED;
        if ($urandom_range(0, 9) < 7) val = ValueW'($urandom_range(0, board.speed_limit + 2));
      end else if (pick < 47) begin
        req = REQ_MODE_GPIO;
      end else if (pick < 54) begin
        req = REQ_MODE_PWM;
      end else if (pick < 59) begin
        req = REQ_FWD;
      end else if (pick < 64) begin
        req = REQ_REV;
      end else if (pick < 70) begin
        req = REQ_STATUS;
      end else if (pick < 82) begin
        req = REQ_SET_RPM;
        if ($urandom_range(0, 9) < 7) val = ValueW'($urandom_range(0, rpm_cap + 3));
      end else if (pick < 88) begin
        req = REQ_AUTO;
      end else if (pick < 95) begin
        req = REQ_STALL;
      end else begin
        req = 4'($urandom_range(REQ_UNKNOWN, ReqCodeMax));
      end
      send_cmd(req, val);
    end
  endtask

  initial begin : stimulus
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed walk through the states with the field extremes
    send_cmd(REQ_STATUS, '0);
    send_cmd(REQ_SPEED, 16'd5);
    send_cmd(REQ_SPEED, 16'hFFFF);
    send_cmd(REQ_SPEED, 16'h7FFF);
    send_cmd(REQ_SET_RPM, 16'h8000);
    send_cmd(REQ_SET_RPM, 16'd1001);
    send_cmd(REQ_SET_RPM, 16'd1000);
    send_cmd(REQ_AUTO, '0);
    send_cmd(REQ_ON, 16'hFFFF);
    send_cmd(REQ_SPEED, 16'd100);
    send_cmd(REQ_SPEED, 16'd101);
    send_cmd(REQ_SPEED, '0);
    send_cmd(REQ_REV, '0);
    send_cmd(REQ_STATUS, '0);
    send_cmd(REQ_ON, '0);
    send_cmd(REQ_MODE_GPIO, '0);
    send_cmd(REQ_STATUS, '0);
    send_cmd(REQ_SPEED, 16'd50);
    send_cmd(REQ_FWD, '0);
    send_cmd(REQ_MODE_PWM, '0);
    send_cmd(REQ_OFF, '0);
    send_cmd(REQ_STALL, '0);
    send_cmd(REQ_STALL, '0);
    send_cmd(REQ_SPEED, 16'd10);
    send_cmd(REQ_SPEED, 16'd101);
    send_cmd(REQ_ON, '0);
    for (int c = REQ_UNKNOWN; c <= ReqCodeMax; c++) send_cmd(4'(c), 16'h7FFF);
    run_random(170);
    drain();

    // widest limits, start duty above full scale; long reply stall midway
    write_limits(1023, 127, 1023);
    run_random(50);
    hold_req = 1'b1;
    run_random(180);
    drain();

    write_limits(0, 0, 0);
    run_random(230);
    drain();

    write_limits($urandom_range(0, 1023), $urandom_range(0, 127), $urandom_range(0, 1023));
    run_random(100);
    drain();
    run_random(130);
    drain();

    // back-to-back traffic to the end
    idle_on = 1'b0;
    write_limits(1000, 100, 1000);
    run_random(230);
    drain();

    if (board.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
